@@ rtl/core/whitespace_tolerant_stream_compare_unit_defines.svh @@
// Assertion macros shared by the stream compare RTL.
`ifndef WHITESPACE_TOLERANT_STREAM_COMPARE_UNIT_DEFINES_SVH
`define WHITESPACE_TOLERANT_STREAM_COMPARE_UNIT_DEFINES_SVH

`ifndef ASSERT_OFF
`define WTSC_ASSERT(label, prop) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) \
    else $error("wtsc assertion failed");
`define WTSC_ASSERT_NEVER(label, cond) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) !(cond)) \
    else $error("wtsc forbidden condition seen");
`else
`define WTSC_ASSERT(label, prop)
`define WTSC_ASSERT_NEVER(label, cond)
`endif

`endif

@@ rtl/core/wtsc_pkg.sv @@
// Types and constants of the whitespace tolerant stream compare unit.
package wtsc_pkg;

  // Stream selector codes
  localparam logic StreamExpected = 1'b0;
  localparam logic StreamProduced = 1'b1;

  // Blank characters
  localparam logic [7:0] ChSpace = 8'h20;
  localparam logic [7:0] ChTab   = 8'h09;
  localparam logic [7:0] ChCr    = 8'h0D;
  localparam logic [7:0] ChLf    = 8'h0A;

  // Verdict codes
  localparam logic [1:0] VerdictAccepted     = 2'd0;
  localparam logic [1:0] VerdictPresentation = 2'd1;
  localparam logic [1:0] VerdictWrong        = 2'd2;

  typedef struct packed {
    logic       func;
    logic [7:0] data_byte;
    logic       is_end;
  } in_item_t;

  typedef struct packed {
    logic [1:0] verdict;
    logic       skew_overflow;
  } out_item_t;

  // Command from the top level to one skew ring
  typedef struct packed {
    logic       feed;
    logic       stream;
    logic [7:0] data_byte;
    logic       other_ended;
    logic       clear;
  } ring_cmd_t;

  // Status from one skew ring
  typedef struct packed {
    logic match;
    logic empty;
    logic overflow;
  } ring_stat_t;

  function automatic logic is_blank(input logic [7:0] b);
    return (b == ChSpace) || (b == ChTab) || (b == ChCr) || (b == ChLf);
  endfunction

endpackage

@@ rtl/core/whitespace_tolerant_stream_compare_unit.sv @@
// Top level of the whitespace tolerant stream compare unit.
// Takes one item per clock cycle from two interleaved byte streams and queues
// one verdict item for the output when the second stream's end item is taken.
// Each of the two skew rings is a SKEW_DEPTH-byte memory that does one write
// (stream ahead) or one read (stream catching up) per item; the popped byte is
// compared in the next cycle and that result is forwarded to the following
// item, so the memory port sets the rate of one item per cycle. Input ready
// drops only while two verdicts wait in the output queue. No clearing pass is
// needed after reset: only written ring entries are ever read.
`include "whitespace_tolerant_stream_compare_unit_defines.svh"

module whitespace_tolerant_stream_compare_unit #(
  parameter int unsigned SKEW_DEPTH = 1024
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_ready_o,
  input  wtsc_pkg::in_item_t in_item_i,
  output logic               out_valid_o,
  input  logic               out_ready_i,
  output wtsc_pkg::out_item_t out_item_o
);

  logic [1:0]           ended_q, ended_d;
  logic                 ovf_seen_q, ovf_seen_d;
  logic                 accept;
  logic                 mine_ended;
  logic                 other_ended;
  logic                 take_byte;
  logic                 finish;
  wtsc_pkg::ring_cmd_t  exact_cmd, strip_cmd;
  wtsc_pkg::ring_stat_t exact_stat, strip_stat;
  wtsc_pkg::out_item_t  res_item;

  assign accept      = in_valid_i && in_ready_o;
  assign mine_ended  = ended_q[in_item_i.func];
  assign other_ended = ended_q[!in_item_i.func];
  assign take_byte   = accept && !mine_ended && !in_item_i.is_end &&
                       (in_item_i.data_byte != wtsc_pkg::ChCr);
  assign finish      = accept && !mine_ended && in_item_i.is_end && other_ended;

  // Route bytes to the rings; drop CR for both rings and all blanks for the stripped ring
  always_comb begin
    exact_cmd.feed        = take_byte;
    exact_cmd.stream      = in_item_i.func;
    exact_cmd.data_byte   = in_item_i.data_byte;
    exact_cmd.other_ended = other_ended;
    exact_cmd.clear       = finish;
    strip_cmd             = exact_cmd;
    strip_cmd.feed        = take_byte && !wtsc_pkg::is_blank(in_item_i.data_byte);
  end

  wtsc_ring #(
    .Depth(SKEW_DEPTH)
  ) u_exact_ring (
    .clk_i (clk_i),
    .rst_ni(rst_ni),
    .cmd_i (exact_cmd),
    .stat_o(exact_stat)
  );

  wtsc_ring #(
    .Depth(SKEW_DEPTH)
  ) u_strip_ring (
    .clk_i (clk_i),
    .rst_ni(rst_ni),
    .cmd_i (strip_cmd),
    .stat_o(strip_stat)
  );

  // Form the verdict
  always_comb begin
    res_item.skew_overflow = ovf_seen_q;
    priority if (ovf_seen_q) begin
      res_item.verdict = wtsc_pkg::VerdictWrong;
    end else if (exact_stat.match && exact_stat.empty) begin
      res_item.verdict = wtsc_pkg::VerdictAccepted;
    end else if (strip_stat.match && strip_stat.empty) begin
      res_item.verdict = wtsc_pkg::VerdictPresentation;
    end else begin
      res_item.verdict = wtsc_pkg::VerdictWrong;
    end
  end

  // Advance end flags and overflow flag; clear both on verdict
  always_comb begin
    ended_d    = ended_q;
    ovf_seen_d = ovf_seen_q || exact_stat.overflow || strip_stat.overflow;
    if (finish) begin
      ended_d    = 2'b00;
      ovf_seen_d = 1'b0;
    end else if (accept && in_item_i.is_end) begin
      ended_d[in_item_i.func] = 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ended_q    <= 2'b00;
      ovf_seen_q <= 1'b0;
    end else begin
      ended_q    <= ended_d;
      ovf_seen_q <= ovf_seen_d;
    end
  end

  wtsc_outq u_outq (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .push_i     (finish),
    .push_item_i(res_item),
    .space_o    (in_ready_o),
    .out_valid_o(out_valid_o),
    .out_ready_i(out_ready_i),
    .out_item_o (out_item_o)
  );

  `WTSC_ASSERT(a_finish_clears, finish |=> ((ended_q == 2'b00) && !ovf_seen_q))
  `WTSC_ASSERT(a_ovf_gives_wrong,
    (out_valid_o && out_item_o.skew_overflow) |-> (out_item_o.verdict == wtsc_pkg::VerdictWrong))
  `WTSC_ASSERT_NEVER(a_verdict_code,
    out_valid_o && (out_item_o.verdict != wtsc_pkg::VerdictAccepted) &&
    (out_item_o.verdict != wtsc_pkg::VerdictPresentation) &&
    (out_item_o.verdict != wtsc_pkg::VerdictWrong))

endmodule

@@ rtl/core/wtsc_ring.sv @@
// Skew ring: byte memory plus head, count and match tracking for one compare path.
`include "whitespace_tolerant_stream_compare_unit_defines.svh"

module wtsc_ring #(
  parameter int unsigned Depth = 1024
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  wtsc_pkg::ring_cmd_t cmd_i,
  output wtsc_pkg::ring_stat_t stat_o
);

  localparam int unsigned AddrW = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int unsigned CntW  = $clog2(Depth + 1);
  localparam int unsigned SumW  = CntW + 1;
  localparam logic [CntW-1:0] CntFull = CntW'(Depth);
  localparam logic [SumW-1:0] SumDepth = SumW'(Depth);
  localparam logic [AddrW-1:0] AddrLast = AddrW'(Depth - 1);

  logic [7:0] mem_q [Depth];

  logic [AddrW-1:0] head_q, head_d;
  logic [CntW-1:0]  count_q, count_d;
  logic             ahead_q, ahead_d;
  logic             match_q, match_d;
  logic             pend_q, pend_d;
  logic [7:0]       pend_byte_q;
  logic [7:0]       rd_q;

  logic             mismatch;
  logic             match_eff;
  logic             wr_en;
  logic             rd_en;
  logic             ovf;
  logic [SumW-1:0]  wr_sum;
  logic [AddrW-1:0] wr_addr;

  // Resolve the compare of the byte popped last cycle
  assign mismatch  = pend_q && (rd_q != pend_byte_q);
  assign match_eff = match_q && !mismatch;

  // Tail address: head plus count, wrapped once
  always_comb begin
    wr_sum = SumW'(head_q) + SumW'(count_q);
    if (wr_sum >= SumDepth) begin
      wr_sum = wr_sum - SumDepth;
    end
    wr_addr = wr_sum[AddrW-1:0];
  end

  // Clear, or decide push, pop, overflow or mismatch for the fed byte
  always_comb begin
    head_d  = head_q;
    count_d = count_q;
    ahead_d = ahead_q;
    match_d = match_eff;
    pend_d  = 1'b0;
    wr_en   = 1'b0;
    rd_en   = 1'b0;
    ovf     = 1'b0;
    if (cmd_i.clear) begin
      head_d  = '0;
      count_d = '0;
      ahead_d = 1'b0;
      match_d = 1'b1;
    end else if (cmd_i.feed && match_eff) begin
      if ((count_q == '0) || (ahead_q == cmd_i.stream)) begin
        if (cmd_i.other_ended) begin
          match_d = 1'b0;
        end else if (count_q == CntFull) begin
          ovf     = 1'b1;
          match_d = 1'b0;
        end else begin
          wr_en   = 1'b1;
          count_d = count_q + 1'b1;
          ahead_d = cmd_i.stream;
        end
      end else begin
        rd_en   = 1'b1;
        pend_d  = 1'b1;
        count_d = count_q - 1'b1;
        head_d  = (head_q == AddrLast) ? '0 : head_q + 1'b1;
      end
    end
  end

  // Control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      head_q  <= '0;
      count_q <= '0;
      ahead_q <= 1'b0;
      match_q <= 1'b1;
      pend_q  <= 1'b0;
    end else begin
      head_q  <= head_d;
      count_q <= count_d;
      ahead_q <= ahead_d;
      match_q <= match_d;
      pend_q  <= pend_d;
    end
  end

  // Hold the fed byte for next cycle's compare against the popped byte
  always_ff @(posedge clk_i) begin
    if (rd_en) begin
      pend_byte_q <= cmd_i.data_byte;
    end
  end

  // Byte memory: one write or one read per item, registered read data
  always_ff @(posedge clk_i) begin
    if (wr_en) begin
      mem_q[wr_addr] <= cmd_i.data_byte;
    end
  end

  always_ff @(posedge clk_i) begin
    if (rd_en) begin
      rd_q <= mem_q[head_q];
    end
  end

  assign stat_o.match    = match_eff;
  assign stat_o.empty    = (count_q == '0);
  assign stat_o.overflow = ovf;

  `WTSC_ASSERT(a_count_in_range, count_q <= CntFull)
  `WTSC_ASSERT(a_overflow_only_full, ovf |-> (count_q == CntFull))
  `WTSC_ASSERT(a_clear_empties, cmd_i.clear |=> ((count_q == '0) && match_q && !pend_q))
  `WTSC_ASSERT_NEVER(a_push_pop_excl, wr_en && rd_en)

endmodule

@@ rtl/core/wtsc_outq.sv @@
// Two-entry result queue between the compare logic and the output channel.
module wtsc_outq (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                push_i,
  input  wtsc_pkg::out_item_t push_item_i,
  output logic                space_o,
  output logic                out_valid_o,
  input  logic                out_ready_i,
  output wtsc_pkg::out_item_t out_item_o
);

  logic [1:0]          cnt_q, cnt_d;
  wtsc_pkg::out_item_t slot0_q, slot1_q;
  logic                pop;
  logic [1:0]          tgt;

  assign pop = out_valid_o && out_ready_i;
  assign tgt = cnt_q - {1'b0, pop};
  assign cnt_d = cnt_q + {1'b0, push_i} - {1'b0, pop};

  // Track fill level
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q <= 2'd0;
    end else begin
      cnt_q <= cnt_d;
    end
  end

  // Shift on drain, write new item at the first free slot
  always_ff @(posedge clk_i) begin
    if (pop && (cnt_q == 2'd2)) begin
      slot0_q <= slot1_q;
    end
    if (push_i) begin
      if (tgt == 2'd0) begin
        slot0_q <= push_item_i;
      end else begin
        slot1_q <= push_item_i;
      end
    end
  end

  assign space_o     = (cnt_q != 2'd2);
  assign out_valid_o = (cnt_q != 2'd0);
  assign out_item_o  = slot0_q;

endmodule
